>>> rtl/qrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_pkg - shared types and constants for the pivot rotation block
// Field widths, request and status codes, and the controller to datapath
// command and status structures.
// ----------------------------------------------------------------------------
package qrp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int ROT_BITS    = 30;
    localparam int OPD_W       = VALUE_WIDTH + 1;
    localparam int PROD_W      = 2 * OPD_W;
    localparam int COF_W       = 2 * VALUE_WIDTH;
    localparam int ACC_W       = 98;
    localparam int S_W         = 66;
    localparam int DR_W        = S_W + 1;
    localparam int Q_W         = ROT_BITS + 1;
    localparam int FIN_W       = ACC_W - ROT_BITS;
    localparam int NUM_ROT     = 9;
    localparam int NUM_RES     = 12;
    localparam int NUM_MAT     = 16;
    localparam int NUM_PIV     = 3;
    localparam int NUM_QUAT    = 4;

    localparam logic signed [VALUE_WIDTH-1:0] ONE_FIX = VALUE_WIDTH'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0]       RND_INIT = ACC_W'(1) <<< (ROT_BITS - 1);

    typedef enum logic [1:0] {
        REQ_LD_MAT  = 2'd0,
        REQ_LD_PIV  = 2'd1,
        REQ_LD_QUAT = 2'd2,
        REQ_COMPUTE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ROW   = 3'd1,
        ST_SINGULAR  = 3'd2,
        ST_ZERO_QUAT = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        SRC_MAT    = 3'd0,
        SRC_QUAT   = 3'd1,
        SRC_ROT    = 3'd2,
        SRC_TRANS  = 3'd3,
        SRC_COF_LO = 3'd4,
        SRC_COF_HI = 3'd5
    } t_src;

    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_LDB = 2'd1,
        OP_MUL = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_1  = 2'd1,
        SH_32 = 2'd2
    } t_shift;

    typedef struct packed {
        t_op        op;
        t_src       src;
        logic [3:0] idx;
        logic       neg;
        t_shift     sh;
        logic       clr;
        logic       rnd;
        logic       to_cof;
        logic       ld_mat;
        logic       ld_piv;
        logic       ld_quat;
        logic       grab_s;
        logic       div_start;
        logic       div_step;
        logic       rot_wr;
        logic       fin;
        logic       ovf_clr;
        logic [3:0] slot;
        logic [1:0] row;
        logic       col3;
        logic       emit;
        logic       emit_res;
        t_status    code;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic bottom_bad;
        logic acc_zero;
        logic ovf;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/qrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_ctrl - sequencer for the pivot rotation block
// Steps the shared multiplier and the divider through the determinant, the
// quaternion norm, the nine rotation entries and the twelve result entries.
// ----------------------------------------------------------------------------
module qrp_ctrl import qrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_index,
    input  t_stat       i_stat,
    output logic        o_in_stall,
    output t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DET, S_DET_WAIT, S_DET_TEST, S_SQ, S_SQ_WAIT, S_SQ_TEST,
        S_NUM, S_NUM_WAIT, S_DIV_INIT, S_DIV, S_DIV_END, S_ENT, S_ENT_WAIT,
        S_ENT_FIN
    } t_state;

    typedef enum logic [1:0] {
        P_RUN, P_CHK, P_EMIT_ST, P_EMIT
    } t_post;

    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic       neg;
    } t_det;

    typedef struct packed {
        logic [1:0] qa;
        logic [1:0] qb;
        logic       neg;
    } t_term;

    t_state     r_state, n_state;
    t_post      r_post, n_post;
    logic [4:0] r_step, n_step;
    logic [3:0] r_k, n_k;
    t_status    r_code, n_code;

    // Six signed triple products of the 3x3 determinant.
    function automatic t_det f_det_term(input logic [3:0] k);
        t_det d;
        unique case (k)
            4'd0:    d = '{a: 4'd0, b: 4'd5, c: 4'd10, neg: 1'b0};
            4'd1:    d = '{a: 4'd0, b: 4'd6, c: 4'd9,  neg: 1'b1};
            4'd2:    d = '{a: 4'd1, b: 4'd4, c: 4'd10, neg: 1'b1};
            4'd3:    d = '{a: 4'd1, b: 4'd6, c: 4'd8,  neg: 1'b0};
            4'd4:    d = '{a: 4'd2, b: 4'd4, c: 4'd9,  neg: 1'b0};
            default: d = '{a: 4'd2, b: 4'd5, c: 4'd8,  neg: 1'b1};
        endcase
        return d;
    endfunction

    // Quaternion product terms of each rotation numerator (w,x,y,z = 0..3).
    function automatic t_term f_num_term(input logic [3:0] k, input logic [1:0] j);
        t_term t;
        unique case (k)
            4'd0:    t = '{qa: j, qb: j, neg: j[1]};
            4'd4:    t = '{qa: j, qb: j, neg: j[0]};
            4'd8:    t = '{qa: j, qb: j, neg: j[0] ^ j[1]};
            4'd1:    t = j[0] ? t_term'{qa: 2'd3, qb: 2'd0, neg: 1'b1}
                              : t_term'{qa: 2'd1, qb: 2'd2, neg: 1'b0};
            4'd2:    t = j[0] ? t_term'{qa: 2'd2, qb: 2'd0, neg: 1'b0}
                              : t_term'{qa: 2'd1, qb: 2'd3, neg: 1'b0};
            4'd3:    t = j[0] ? t_term'{qa: 2'd3, qb: 2'd0, neg: 1'b0}
                              : t_term'{qa: 2'd1, qb: 2'd2, neg: 1'b0};
            4'd5:    t = j[0] ? t_term'{qa: 2'd1, qb: 2'd0, neg: 1'b1}
                              : t_term'{qa: 2'd2, qb: 2'd3, neg: 1'b0};
            4'd6:    t = j[0] ? t_term'{qa: 2'd2, qb: 2'd0, neg: 1'b1}
                              : t_term'{qa: 2'd1, qb: 2'd3, neg: 1'b0};
            default: t = j[0] ? t_term'{qa: 2'd1, qb: 2'd0, neg: 1'b0}
                              : t_term'{qa: 2'd2, qb: 2'd3, neg: 1'b0};
        endcase
        return t;
    endfunction

    always_comb begin
        t_det       det;
        t_term      term;
        logic [1:0] j;
        logic [1:0] row;
        logic [1:0] col;
        logic       diag;
        logic [4:0] num_last;

        n_state  = r_state;
        n_post   = r_post;
        n_step   = r_step;
        n_k      = r_k;
        n_code   = r_code;
        o_cmd    = '0;
        det      = f_det_term(r_k);
        j        = r_step[2:1];
        term     = f_num_term(r_k, j);
        row      = r_k[3:2];
        col      = r_k[1:0];
        diag     = (r_k == 4'd0) || (r_k == 4'd4) || (r_k == 4'd8);
        num_last = diag ? 5'd7 : 5'd3;
        o_in_stall = (r_state != S_IDLE) || (r_post != P_RUN);

        if (r_post != P_RUN) begin
            unique case (r_post)
                P_CHK: begin
                    if (i_stat.ovf) begin
                        n_code = ST_OVERFLOW;
                        n_post = P_EMIT_ST;
                    end else begin
                        n_k    = '0;
                        n_post = P_EMIT;
                    end
                end
                P_EMIT_ST: begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = r_code;
                        o_cmd.last = 1'b1;
                        n_post     = P_RUN;
                    end
                end
                P_EMIT: begin
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_res = 1'b1;
                        o_cmd.code     = ST_OK;
                        o_cmd.slot     = r_k;
                        o_cmd.last     = (r_k == 4'(NUM_RES - 1));
                        if (r_k == 4'(NUM_RES - 1)) begin
                            n_post = P_RUN;
                        end else begin
                            n_k = r_k + 4'd1;
                        end
                    end
                end
                default: n_post = P_RUN;
            endcase
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (t_req'(i_req_type))
                            REQ_LD_MAT:  o_cmd.ld_mat  = 1'b1;
                            REQ_LD_PIV:  o_cmd.ld_piv  = (i_index < 4'(NUM_PIV));
                            REQ_LD_QUAT: o_cmd.ld_quat = (i_index < 4'(NUM_QUAT));
                            REQ_COMPUTE: n_state = S_CHECK;
                        endcase
                    end
                end
                S_CHECK: begin
                    o_cmd.ovf_clr = 1'b1;
                    if (i_stat.bottom_bad) begin
                        n_code  = ST_BAD_ROW;
                        n_post  = P_EMIT_ST;
                        n_state = S_IDLE;
                    end else begin
                        n_step  = '0;
                        n_k     = '0;
                        n_state = S_DET;
                    end
                end
                S_DET: begin
                    o_cmd.neg = det.neg;
                    unique case (r_step)
                        5'd0: begin
                            o_cmd.op  = OP_LDB;
                            o_cmd.idx = det.a;
                        end
                        5'd1: begin
                            o_cmd.op     = OP_MUL;
                            o_cmd.idx    = det.b;
                            o_cmd.to_cof = 1'b1;
                        end
                        5'd2: begin
                            o_cmd.op  = OP_LDB;
                            o_cmd.idx = det.c;
                        end
                        5'd3: begin
                            o_cmd.op  = OP_MUL;
                            o_cmd.src = SRC_COF_LO;
                            o_cmd.clr = (r_k == 4'd0);
                        end
                        default: begin
                            o_cmd.op  = OP_MUL;
                            o_cmd.src = SRC_COF_HI;
                            o_cmd.sh  = SH_32;
                        end
                    endcase
                    if (r_step == 5'd4) begin
                        n_step = '0;
                        if (r_k == 4'd5) begin
                            n_state = S_DET_WAIT;
                        end else begin
                            n_k = r_k + 4'd1;
                        end
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
                S_DET_WAIT: n_state = S_DET_TEST;
                S_DET_TEST: begin
                    if (i_stat.acc_zero) begin
                        n_code  = ST_SINGULAR;
                        n_post  = P_EMIT_ST;
                        n_state = S_IDLE;
                    end else begin
                        n_step  = '0;
                        n_state = S_SQ;
                    end
                end
                S_SQ: begin
                    o_cmd.op  = r_step[0] ? OP_MUL : OP_LDB;
                    o_cmd.src = SRC_QUAT;
                    o_cmd.idx = {2'b00, j};
                    o_cmd.clr = (r_step == 5'd1);
                    if (r_step == 5'd7) begin
                        n_state = S_SQ_WAIT;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
                S_SQ_WAIT: n_state = S_SQ_TEST;
                S_SQ_TEST: begin
                    o_cmd.grab_s = 1'b1;
                    if (i_stat.acc_zero) begin
                        n_code  = ST_ZERO_QUAT;
                        n_post  = P_EMIT_ST;
                        n_state = S_IDLE;
                    end else begin
                        n_step  = '0;
                        n_k     = '0;
                        n_state = S_NUM;
                    end
                end
                S_NUM: begin
                    o_cmd.op  = r_step[0] ? OP_MUL : OP_LDB;
                    o_cmd.src = SRC_QUAT;
                    o_cmd.idx = {2'b00, r_step[0] ? term.qb : term.qa};
                    o_cmd.neg = term.neg;
                    o_cmd.sh  = diag ? SH_0 : SH_1;
                    o_cmd.clr = (r_step == 5'd1);
                    if (r_step == num_last) begin
                        n_state = S_NUM_WAIT;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
                S_NUM_WAIT: n_state = S_DIV_INIT;
                S_DIV_INIT: begin
                    o_cmd.div_start = 1'b1;
                    n_step          = '0;
                    n_state         = S_DIV;
                end
                S_DIV: begin
                    o_cmd.div_step = 1'b1;
                    if (r_step == 5'(Q_W - 1)) begin
                        n_state = S_DIV_END;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
                S_DIV_END: begin
                    o_cmd.rot_wr = 1'b1;
                    o_cmd.slot   = r_k;
                    n_step       = '0;
                    if (r_k == 4'(NUM_ROT - 1)) begin
                        n_k     = '0;
                        n_state = S_ENT;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_NUM;
                    end
                end
                S_ENT: begin
                    if (r_step[0]) begin
                        o_cmd.op  = OP_MUL;
                        o_cmd.src = (col == 2'd3) ? SRC_TRANS : SRC_MAT;
                        o_cmd.idx = (col == 2'd3) ? {2'b00, j} : {j, col};
                    end else begin
                        o_cmd.op  = OP_LDB;
                        o_cmd.src = SRC_ROT;
                        o_cmd.idx = {2'b00, row} * 4'd3 + {2'b00, j};
                    end
                    o_cmd.clr = (r_step == 5'd1);
                    o_cmd.rnd = (r_step == 5'd1);
                    if (r_step == 5'd5) begin
                        n_state = S_ENT_WAIT;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
                S_ENT_WAIT: n_state = S_ENT_FIN;
                S_ENT_FIN: begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.slot = r_k;
                    o_cmd.row  = row;
                    o_cmd.col3 = (col == 2'd3);
                    n_step     = '0;
                    if (r_k == 4'(NUM_RES - 1)) begin
                        n_post  = P_CHK;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_ENT;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post  <= P_RUN;
            r_step  <= '0;
            r_k     <= '0;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
            r_step  <= n_step;
            r_k     <= n_k;
            r_code  <= n_code;
        end
    end

endmodule

>>> rtl/qrp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_dp - datapath of the pivot rotation block
// Element stores, one 33x33 multiplier feeding a wide accumulator, a
// restoring divider, the result buffer and the output register.
// ----------------------------------------------------------------------------
module qrp_dp import qrp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic [3:0]                    i_index,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_out_stall,
    output t_stat                         o_stat,
    output logic                          o_out_valid,
    output logic [3:0]                    o_entry_index,
    output logic signed [VALUE_WIDTH-1:0] o_entry_value,
    output logic [2:0]                    o_status,
    output logic                          o_last
);

    logic signed [VALUE_WIDTH-1:0] r_mat  [NUM_MAT];
    logic signed [VALUE_WIDTH-1:0] r_piv  [NUM_PIV];
    logic signed [VALUE_WIDTH-1:0] r_quat [NUM_QUAT];
    logic signed [VALUE_WIDTH-1:0] r_rot  [NUM_ROT];
    logic signed [VALUE_WIDTH-1:0] r_res  [NUM_RES];

    logic signed [OPD_W-1:0]  r_b;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_pneg;
    t_shift                   r_psh;
    logic                     r_pclr;
    logic                     r_prnd;
    logic                     r_pcof;
    logic signed [ACC_W-1:0]  r_acc;
    logic [COF_W-1:0]         r_cof;
    logic [S_W-1:0]           r_s;

    logic [DR_W-1:0] r_rem;
    logic [DR_W-1:0] r_den;
    logic [Q_W-1:0]  r_qt;
    logic [Q_W-1:0]  r_bits;
    logic            r_dneg;
    logic            r_ovf;

    logic                    r_ov;
    logic [3:0]              r_oidx;
    logic [VALUE_WIDTH-1:0]  r_oval;
    t_status                 r_ost;
    logic                    r_olast;

    logic [3:0]                    mat_addr;
    logic [1:0]                    piv_addr;
    logic signed [VALUE_WIDTH-1:0] mat_rd;
    logic signed [VALUE_WIDTH-1:0] piv_rd;
    logic signed [OPD_W-1:0]       opnd;
    logic signed [PROD_W-1:0]      prod_c;
    logic signed [ACC_W-1:0]       pext;
    logic signed [ACC_W-1:0]       pshift;
    logic signed [ACC_W-1:0]       base;
    logic signed [DR_W-1:0]        num;
    logic [DR_W-1:0]               mag;
    logic [DR_W-1:0]               dsh;
    logic signed [VALUE_WIDTH-1:0] qv;
    logic signed [FIN_W-1:0]       fin_v;
    logic                          fin_fits;
    logic                          out_free;

    // Single read address per store.
    always_comb begin
        mat_addr = (i_cmd.src == SRC_TRANS) ? {i_cmd.idx[1:0], 2'b11} : i_cmd.idx;
        piv_addr = i_cmd.fin ? i_cmd.row : i_cmd.idx[1:0];
        mat_rd   = r_mat[mat_addr];
        piv_rd   = r_piv[piv_addr];
        unique case (i_cmd.src)
            SRC_MAT:    opnd = OPD_W'(mat_rd);
            SRC_QUAT:   opnd = OPD_W'(r_quat[i_cmd.idx[1:0]]);
            SRC_ROT:    opnd = OPD_W'(r_rot[i_cmd.idx]);
            SRC_TRANS:  opnd = OPD_W'(mat_rd) - OPD_W'(piv_rd);
            SRC_COF_LO: opnd = {1'b0, r_cof[VALUE_WIDTH-1:0]};
            SRC_COF_HI: opnd = {r_cof[COF_W-1], r_cof[COF_W-1:VALUE_WIDTH]};
            default:    opnd = '0;
        endcase
    end

    assign prod_c = opnd * r_b;

    always_comb begin
        pext = ACC_W'(r_prod);
        unique case (r_psh)
            SH_1:    pshift = pext <<< 1;
            SH_32:   pshift = pext <<< 32;
            default: pshift = pext;
        endcase
        if (r_pclr) begin
            base = r_prnd ? RND_INIT : '0;
        end else begin
            base = r_acc;
        end
    end

    // Divider operands: magnitude of the numerator plus the rounding half.
    always_comb begin
        num = r_acc[DR_W-1:0];
        mag = num[DR_W-1] ? DR_W'(-num) : DR_W'(num);
        dsh = {r_rem[DR_W-2:0], r_bits[Q_W-1]};
        qv  = VALUE_WIDTH'(r_qt);
    end

    always_comb begin
        fin_v = FIN_W'(r_acc >>> ROT_BITS);
        if (i_cmd.col3) begin
            fin_v = fin_v + FIN_W'(piv_rd);
        end
        fin_fits = (fin_v[FIN_W-1:VALUE_WIDTH-1] == '0) ||
                   (fin_v[FIN_W-1:VALUE_WIDTH-1] == '1);
    end

    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        o_stat.bottom_bad = (r_mat[12] != '0) || (r_mat[13] != '0) ||
                            (r_mat[14] != '0) || (r_mat[15] != ONE_FIX);
        o_stat.acc_zero   = (r_acc == '0);
        o_stat.ovf        = r_ovf;
        o_stat.out_free   = out_free;
    end

    // Stores, operand latch, product stage, accumulator, divider, result buffer and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_mat) begin
            r_mat[i_index] <= i_value;
        end
        if (i_cmd.ld_piv) begin
            r_piv[i_index[1:0]] <= i_value;
        end
        if (i_cmd.ld_quat) begin
            r_quat[i_index[1:0]] <= i_value;
        end
        if (i_cmd.op == OP_LDB) begin
            r_b <= opnd;
        end
        r_prod <= prod_c;
        r_pneg <= i_cmd.neg;
        r_psh  <= i_cmd.sh;
        r_pclr <= i_cmd.clr;
        r_prnd <= i_cmd.rnd;
        r_pcof <= i_cmd.to_cof;
        if (r_pv) begin
            if (r_pcof) begin
                r_cof <= r_prod[COF_W-1:0];
            end else begin
                r_acc <= base + (r_pneg ? -pshift : pshift);
            end
        end
        if (i_cmd.grab_s) begin
            r_s <= r_acc[S_W-1:0];
        end
        if (i_cmd.div_start) begin
            r_rem  <= mag + DR_W'(r_s >> Q_W);
            r_den  <= {r_s, 1'b0};
            r_bits <= r_s[Q_W-1:0];
            r_qt   <= '0;
            r_dneg <= num[DR_W-1];
        end else if (i_cmd.div_step) begin
            if (dsh >= r_den) begin
                r_rem <= dsh - r_den;
                r_qt  <= {r_qt[Q_W-2:0], 1'b1};
            end else begin
                r_rem <= dsh;
                r_qt  <= {r_qt[Q_W-2:0], 1'b0};
            end
            r_bits <= r_bits << 1;
        end
        if (i_cmd.rot_wr) begin
            r_rot[i_cmd.slot] <= r_dneg ? -qv : qv;
        end
        if (i_cmd.fin) begin
            r_res[i_cmd.slot] <= fin_v[VALUE_WIDTH-1:0];
        end
        if (i_cmd.emit) begin
            r_oidx  <= i_cmd.slot;
            r_oval  <= i_cmd.emit_res ? r_res[i_cmd.slot] : '0;
            r_ost   <= i_cmd.code;
            r_olast <= i_cmd.last;
        end
    end

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_ovf <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_pv <= (i_cmd.op == OP_MUL);
            if (i_cmd.ovf_clr) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.fin && !fin_fits) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_entry_index = r_oidx;
    assign o_entry_value = r_oval;
    assign o_status      = r_ost;
    assign o_last        = r_olast;

endmodule

>>> rtl/quaternion_rotate_about_pivot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_about_pivot - rotate an affine matrix about a pivot
// Top level: sequencer and datapath joined by a command and a status
// structure, plus a handful of consistency checks.
// ----------------------------------------------------------------------------
// Load a 4x4 affine matrix (row-major), a pivot point and a quaternion
// (w,x,y,z) one element per item, all signed Q16.16; loads give no
// result. A compute item checks the bottom row (0,0,0,1), then the exact
// 3x3 determinant, then that the quaternion is nonzero, and on success
// emits the twelve entries of the top three rows of R*(M - P) + P, index
// 0 to 11, last set on entry 11; any failure, or an entry that leaves the
// 32-bit range, gives a single status item instead. The determinant and
// the quaternion norm go through the one shared 33x33 multiplier, each of
// the nine rotation entries through the 31-step restoring divider, and
// then the twelve result entries are formed and the items emitted. Input
// stall stays high from the compute item until its last item is in the
// output register; the output register holds a result while the receiver
// stalls.
// ----------------------------------------------------------------------------
module quaternion_rotate_about_pivot import qrp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [3:0]                    i_index,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [3:0]                    o_entry_index,
    output logic signed [VALUE_WIDTH-1:0] o_entry_value,
    output logic [2:0]                    o_status,
    output logic                          o_last
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence the multiplier, divider and result emission.
    qrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_index    (i_index),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Hold the stores and do the arithmetic.
    qrp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_out_stall   (i_out_stall),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_entry_index (o_entry_index),
        .o_entry_value (o_entry_value),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    // A status item is always the only and final item of its compute.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_last && o_entry_value == '0))
        else $error("status item without last or with nonzero value");

    // Result indices stay within the top three rows.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_index <= 4'(NUM_RES - 1)))
        else $error("result index out of range");

    // Take no further item once a compute has been accepted.
    a_compute_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type == REQ_COMPUTE) |=> o_in_stall)
        else $error("input accepted straight after a compute");

    // The sequencer emits only while the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted over a held output");

endmodule

>>> bench/quaternion_rotate_about_pivot_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_about_pivot_tb - self-checking bench for the pivot rotator
// Loads matrix, pivot and quaternion stores, then issues compute items:
// directed cases for identity, bad bottom row, singular matrix, zero
// quaternion, overflow and ignored loads, then random load-and-compute
// sequences mixed with noise. A local fixed-point transform predictor builds
// the expected result items; a checker compares every accepted result item
// against the oldest expectation. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module quaternion_rotate_about_pivot_tb;
    import qrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 110;
    localparam int TAIL_CYCLES    = 700;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        logic [2:0]  st;
        logic        lst;
    } t_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [3:0]  i_index = '0;
    logic signed [VALUE_WIDTH-1:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_entry_index;
    logic signed [VALUE_WIDTH-1:0] o_entry_value;
    logic [2:0]  o_status;
    logic        o_last;

    // Local copy of the block's stores, widened to 64 bits for the arithmetic.
    longint mat_copy [NUM_MAT];
    longint piv_copy [NUM_PIV];
    longint quat_copy[NUM_QUAT];

    t_entry expected_entries[$];
    int     error_count = 0;
    int     burst_left = 0;
    int     items_sent = 0;
    int     idle_count = 0;
    int     stall_cycle = 0;

    quaternion_rotate_about_pivot u_top (.*);

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Transform predictor
    // ------------------------------------------------------------------------
    function automatic void push_status(t_status code);
        t_entry e;
        e.idx = '0;
        e.val = '0;
        e.st  = code;
        e.lst = 1'b1;
        expected_entries.push_back(e);
    endfunction

    // Work out the result items of one compute item from the stored operands.
    function automatic void predict_transform();
        logic signed [127:0] det, s, w, x, y, z, mg, qn, acc;
        logic signed [127:0] nm[9];
        logic signed [127:0] rot[9];
        logic signed [127:0] res[12];
        longint opnd;
        bit     ovf;
        t_entry e;
        ovf = 1'b0;
        // bottom row must be exactly 0,0,0,1
        if (mat_copy[12] != 0 || mat_copy[13] != 0 || mat_copy[14] != 0 ||
            mat_copy[15] != 64'sd65536) begin
            push_status(ST_BAD_ROW);
            return;
        end
        det = 128'(mat_copy[0]) * (128'(mat_copy[5]) * mat_copy[10]
                                   - 128'(mat_copy[6]) * mat_copy[9])
            - 128'(mat_copy[1]) * (128'(mat_copy[4]) * mat_copy[10]
                                   - 128'(mat_copy[6]) * mat_copy[8])
            + 128'(mat_copy[2]) * (128'(mat_copy[4]) * mat_copy[9]
                                   - 128'(mat_copy[5]) * mat_copy[8]);
        if (det == 0) begin
            push_status(ST_SINGULAR);
            return;
        end
        w = 128'(quat_copy[0]);
        x = 128'(quat_copy[1]);
        y = 128'(quat_copy[2]);
        z = 128'(quat_copy[3]);
        s = w * w + x * x + y * y + z * z;
        if (s == 0) begin
            push_status(ST_ZERO_QUAT);
            return;
        end
        nm[0] = s - 2 * (y * y + z * z);
        nm[1] = 2 * (x * y - z * w);
        nm[2] = 2 * (x * z + y * w);
        nm[3] = 2 * (x * y + z * w);
        nm[4] = s - 2 * (x * x + z * z);
        nm[5] = 2 * (y * z - x * w);
        nm[6] = 2 * (x * z - y * w);
        nm[7] = 2 * (y * z + x * w);
        nm[8] = s - 2 * (x * x + y * y);
        // round to nearest with 30 fraction bits, ties away from zero
        for (int k = 0; k < 9; k++) begin
            mg = (nm[k] < 0) ? -nm[k] : nm[k];
            qn = (2 * (mg <<< ROT_BITS) + s) / (2 * s);
            rot[k] = (nm[k] < 0) ? -qn : qn;
        end
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 4; col++) begin
                acc = 128'sd536870912;
                for (int k = 0; k < 3; k++) begin
                    opnd = (col < 3) ? mat_copy[k * 4 + col]
                                     : mat_copy[k * 4 + 3] - piv_copy[k];
                    acc = acc + rot[row * 3 + k] * 128'(opnd);
                end
                acc = acc >>> ROT_BITS;
                if (col == 3)
                    acc = acc + 128'(piv_copy[row]);
                if (acc < -128'sd2147483648 || acc > 128'sd2147483647)
                    ovf = 1'b1;
                res[row * 4 + col] = acc;
            end
        end
        if (ovf) begin
            push_status(ST_OVERFLOW);
            return;
        end
        for (int k = 0; k < NUM_RES; k++) begin
            e.idx = 4'(k);
            e.val = res[k][31:0];
            e.st  = ST_OK;
            e.lst = (k == NUM_RES - 1);
            expected_entries.push_back(e);
        end
    endfunction

    // Apply one accepted item to the local stores.
    function automatic void apply_item(t_req rq, logic [3:0] ix, logic [31:0] v);
        case (rq)
            REQ_LD_MAT:  mat_copy[ix] = longint'(signed'(v));
            REQ_LD_PIV:  if (ix < NUM_PIV) piv_copy[ix] = longint'(signed'(v));
            REQ_LD_QUAT: if (ix < NUM_QUAT) quat_copy[ix] = longint'(signed'(v));
            default:     predict_transform();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    // Send one item; called and returns at a falling edge. Bursts of random
    // length are mostly separated by random gaps with valid low.
    task automatic send_item(t_req rq, logic [3:0] ix, logic [31:0] v);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_req_type = rq;
        i_index    = ix;
        i_value    = v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_item(rq, ix, v);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_entries.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_fix();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 524288)) - 262144);
            2:       return 32'(($signed($urandom_range(0, 8)) - 4) * 65536);
            default: return '0;
        endcase
    endfunction

    task automatic load_identity(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        for (int k = 0; k < NUM_MAT; k++)
            send_item(REQ_LD_MAT, 4'(k), (k % 5 == 0) ? 32'h0001_0000 : 32'h0);
        send_item(REQ_LD_MAT, 4'd3, tx);
        send_item(REQ_LD_MAT, 4'd7, ty);
        send_item(REQ_LD_MAT, 4'd11, tz);
    endtask

    task automatic load_quat(logic [31:0] qw, logic [31:0] qx,
                             logic [31:0] qy, logic [31:0] qz);
        send_item(REQ_LD_QUAT, 4'd0, qw);
        send_item(REQ_LD_QUAT, 4'd1, qx);
        send_item(REQ_LD_QUAT, 4'd2, qy);
        send_item(REQ_LD_QUAT, 4'd3, qz);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Fill every store first so that no compute reads an unwritten entry.
    task automatic test_identity();
        load_identity(32'h0002_0000, 32'hFFFD_0000, 32'h7FFF_FFFF);
        send_item(REQ_LD_PIV, 4'd0, 32'h0001_8000);
        send_item(REQ_LD_PIV, 4'd1, 32'h8000_0000);
        send_item(REQ_LD_PIV, 4'd2, 32'h0);
        load_quat(32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_item(REQ_COMPUTE, 4'hF, 32'hFFFF_FFFF);
        // quarter turn about z with an unnormalised quaternion
        load_quat(32'h0003_0000, 32'h0, 32'h0, 32'h0003_0000);
        send_item(REQ_LD_PIV, 4'd1, 32'h0004_0000);
        send_item(REQ_COMPUTE, 4'h0, 32'h0);
    endtask

    task automatic test_bad_row();
        send_item(REQ_LD_MAT, 4'd14, 32'h0000_0001);
        send_item(REQ_COMPUTE, 4'd5, 32'h1234_5678);
        send_item(REQ_LD_MAT, 4'd14, 32'h0);
        send_item(REQ_LD_MAT, 4'd15, 32'h0001_0001);
        send_item(REQ_COMPUTE, 4'd0, 32'h0);
        send_item(REQ_LD_MAT, 4'd15, 32'h0001_0000);
    endtask

    task automatic test_singular();
        // make row 1 a copy of row 0 in the 3x3 part
        send_item(REQ_LD_MAT, 4'd5, 32'h0);
        send_item(REQ_LD_MAT, 4'd4, 32'h0001_0000);
        send_item(REQ_COMPUTE, 4'd0, 32'h0);
        send_item(REQ_LD_MAT, 4'd4, 32'h0);
        send_item(REQ_LD_MAT, 4'd5, 32'h0001_0000);
    endtask

    task automatic test_zero_quat_and_ignored_loads();
        load_quat(32'h0, 32'h0, 32'h0, 32'h0);
        // out-of-range pivot and quaternion loads must leave the stores alone
        send_item(REQ_LD_PIV, 4'd3, 32'h7FFF_FFFF);
        send_item(REQ_LD_QUAT, 4'd15, 32'h0001_0000);
        send_item(REQ_COMPUTE, 4'd0, 32'h0);
        send_item(REQ_LD_QUAT, 4'd4, 32'h0001_0000);
        send_item(REQ_LD_QUAT, 4'd2, 32'h8000_0000);
        send_item(REQ_COMPUTE, 4'd0, 32'h0);
    endtask

    task automatic test_overflow();
        // half turn about z negates the most negative entry
        load_quat(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_item(REQ_LD_MAT, 4'd0, 32'h8000_0000);
        send_item(REQ_COMPUTE, 4'd0, 32'h0);
        send_item(REQ_LD_MAT, 4'd0, 32'h0001_0000);
        wait_drained();
    endtask

    // Well-formed load-and-compute sequences with random content, plus noise.
    task automatic test_random_sequences();
        int start_items;
        int n;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            if ($urandom_range(0, 4) != 0) begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_item(REQ_LD_MAT, 4'($urandom_range(0, 11)), rand_fix());
                if ($urandom_range(0, 9) == 0)
                    send_item(REQ_LD_MAT, 4'($urandom_range(12, 15)), rand_fix());
                else if ($urandom_range(0, 3) == 0) begin
                    send_item(REQ_LD_MAT, 4'd12, 32'h0);
                    send_item(REQ_LD_MAT, 4'd15, 32'h0001_0000);
                end
                if ($urandom_range(0, 1))
                    send_item(REQ_LD_PIV, 4'($urandom_range(0, 15)), rand_fix());
                for (int k = 0; k < NUM_QUAT; k++)
                    if ($urandom_range(0, 2) != 0)
                        send_item(REQ_LD_QUAT, 4'(k), rand_fix());
                send_item(REQ_COMPUTE, 4'($urandom), $urandom);
            end else begin
                send_item(t_req'($urandom_range(0, 3)), 4'($urandom), $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_entry e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_entries.size() == 0) begin
                report_mismatch("unexpected result item index", 32'(o_entry_index), 32'h0);
            end else begin
                e = expected_entries.pop_front();
                if (o_entry_index != e.idx)
                    report_mismatch("entry_index", 32'(o_entry_index), 32'(e.idx));
                if (o_entry_value != e.val)
                    report_mismatch("entry_value", o_entry_value, e.val);
                if (o_status != e.st)
                    report_mismatch("status", 32'(o_status), 32'(e.st));
                if (o_last != e.lst)
                    report_mismatch("last", 32'(o_last), 32'(e.lst));
            end
        end
    end

    // Receiver stall: cycle through no stall, sparse, pulsed and heavy phases.
    always @(negedge i_clk) begin
        stall_cycle++;
        case ((stall_cycle / 256) % 4)
            0:       i_out_stall = 1'b0;
            1:       i_out_stall = ($urandom_range(0, 2) == 0);
            2:       i_out_stall = ((stall_cycle % 13) < 6);
            default: i_out_stall = ($urandom_range(0, 1) == 1);
        endcase
    end

    // Watchdog: count cycles with no item accepted on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_identity();
        test_bad_row();
        test_singular();
        test_zero_quat_and_ignored_loads();
        test_overflow();
        test_random_sequences();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_entries.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
